>>> hdl/fir_filter_direct_form_defines.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion shorthands, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_DIRECT_FORM_DEFINES_SVH
`define FIR_FILTER_DIRECT_FORM_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define FIR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define FIR_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> hdl/fir_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Sizes, fixed-point constants and operation codes of the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int MAX_TAPS  = 32;
	localparam int TAP_W     = $clog2(MAX_TAPS);
	localparam int CNT_W     = $clog2(MAX_TAPS + 1);
	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 14;

	// Coefficients are fed to the multiplier one digit at a time, top digit first.
	localparam int DIGIT_W   = 4;
	localparam int DIGITS    = DATA_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(DIGITS);
	localparam int DPROD_W   = DATA_W + DIGIT_W + 1;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + CNT_W;
	localparam int Q_W       = ACC_W - FRAC_BITS;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	typedef logic signed [DATA_W-1:0] word_t;

endpackage

>>> hdl/fir_filter_direct_form.sv
// ----------------------------------------------------------------------------
// Direct-form FIR filter
// Up to 32-tap FIR with a loadable Q2.14 coefficient store and a digit-serial
// multiply-accumulate, rounded and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Each input beat either filters one sample (tuser = 0) or loads one
// coefficient (tuser = 1). A sample enters the front of the delay line and
// yields one output beat: the tap sum, rounded half up at bit 14 and clipped
// to signed 16 bits, with tuser set when it was clipped. A coefficient load
// yields no output and is dropped when its index is at or above the tap
// count. For a sample, the single 16 x 4 bit multiplier walks all 32 taps,
// four coefficient digits per tap, then ST_ACC finishes the sum and ST_OUT
// rounds and registers the result once the output register is free. The
// next beat is taken once the result sits in the output register, so a
// stalled output only holds the block when a second result is ready behind
// it. Writing the tap count (1 to 32, 0 is ignored, larger values clip to
// 32) clears every delay and coefficient entry at or above the new count.
// The tap count channel is held off while a sample is being worked on, and
// a pending tap count write holds off the input stream for that cycle.
`include "fir_filter_direct_form_defines.svh"

module fir_filter_direct_form (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fir_pkg::IN_TDATA_W-1:0]      s_tdata,  // sample, coeff_index, coeff_value
	input  logic                                s_tuser,  // operation
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fir_pkg::OUT_TDATA_W-1:0]     m_tdata,  // filtered
	output logic                                m_tuser,  // saturated
	// tap count register
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fir_pkg::CNT_W-1:0]           cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                          state_q;
	logic [fir_pkg::CNT_W-1:0]           tap_count_q;
	logic [fir_pkg::TAP_W-1:0]           tap_q;
	logic [fir_pkg::DIG_CNT_W-1:0]       digit_q;
	logic                                part_done_q;
	logic signed [fir_pkg::PROD_W-1:0]   part_q;
	logic signed [fir_pkg::ACC_W-1:0]    acc_q;
	fir_pkg::word_t                      delay_q [fir_pkg::MAX_TAPS];
	fir_pkg::word_t                      coef_q  [fir_pkg::MAX_TAPS];
	logic                                m_tvalid_q;
	logic [fir_pkg::OUT_TDATA_W-1:0]     m_tdata_q;
	logic                                m_tuser_q;

	// input beat fields
	fir_pkg::word_t                      in_sample;
	logic [fir_pkg::TAP_W-1:0]           in_index;
	fir_pkg::word_t                      in_coef;
	logic                                s_fire;
	logic                                cfg_fire;

	// datapath
	logic signed [fir_pkg::DIGIT_W:0]    digit;
	logic signed [fir_pkg::DPROD_W-1:0]  dprod;
	logic signed [fir_pkg::PROD_W-1:0]   part_next;
	logic signed [fir_pkg::ACC_W-1:0]    rounded;
	logic signed [fir_pkg::Q_W-1:0]      q;
	logic                                sat_hi;
	logic                                sat_lo;
	logic                                last_digit;
	logic                                last_tap;
	logic                                out_free;
	logic [fir_pkg::CNT_W-1:0]           new_count;

	assign in_sample = s_tdata[fir_pkg::DATA_W-1:0];
	assign in_index  = s_tdata[fir_pkg::DATA_W +: fir_pkg::TAP_W];
	assign in_coef   = s_tdata[fir_pkg::DATA_W + fir_pkg::TAP_W +: fir_pkg::DATA_W];

	// a tap count write goes first, so it never meets an input beat
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign out_free  = !m_tvalid_q || m_tready;

	// clip the written tap count to the store depth
	assign new_count = (cfg_data > fir_pkg::CNT_W'(fir_pkg::MAX_TAPS))
		? fir_pkg::CNT_W'(fir_pkg::MAX_TAPS) : cfg_data;

	assign last_digit = (digit_q == fir_pkg::DIG_CNT_W'(fir_pkg::DIGITS - 1));
	assign last_tap   = (tap_q == fir_pkg::TAP_W'(fir_pkg::MAX_TAPS - 1));

	// Head digit of the coefficient ring. The top digit carries the sign,
	// the lower digits are plain magnitudes.
	always_comb begin
		if (digit_q == '0) begin
			digit = {coef_q[0][fir_pkg::DATA_W-1],
				coef_q[0][fir_pkg::DATA_W-1 -: fir_pkg::DIGIT_W]};
		end else begin
			digit = {1'b0, coef_q[0][fir_pkg::DATA_W-1 -: fir_pkg::DIGIT_W]};
		end
	end

	// Horner step: shift the running product up one digit and add the new one.
	assign dprod = fir_pkg::DPROD_W'(delay_q[0]) * fir_pkg::DPROD_W'(digit);

	always_comb begin
		if (digit_q == '0) begin
			part_next = fir_pkg::PROD_W'(dprod);
		end else begin
			part_next = (part_q <<< fir_pkg::DIGIT_W) + fir_pkg::PROD_W'(dprod);
		end
	end

	// Round half up at the binary point, then clip to 16 bits.
	assign rounded = acc_q + fir_pkg::ACC_W'(1 << (fir_pkg::FRAC_BITS - 1));
	assign q       = rounded[fir_pkg::ACC_W-1:fir_pkg::FRAC_BITS];
	assign sat_hi  = (q > fir_pkg::Q_W'(32767));
	assign sat_lo  = (q < -fir_pkg::Q_W'(32768));

	// control, tap count and output valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_count_q <= fir_pkg::CNT_W'(fir_pkg::MAX_TAPS);
			tap_q       <= '0;
			digit_q     <= '0;
			part_done_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// load a fresh result, else drop the one just taken
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tuser == fir_pkg::OP_SAMPLE) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					digit_q     <= digit_q + 1'b1;
					part_done_q <= last_digit;
					if (last_digit) begin
						tap_q <= tap_q + 1'b1;
						if (last_tap) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					part_done_q <= 1'b0;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_fire && cfg_data != '0) begin
				tap_count_q <= new_count;
			end
		end
	end

	// accumulator and output payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			acc_q <= '0;
		end else if (part_done_q) begin
			acc_q <= acc_q + fir_pkg::ACC_W'(part_q);
		end
		if (state_q == ST_MAC) begin
			part_q <= part_next;
		end
		if (state_q == ST_OUT && out_free) begin
			if (sat_hi) begin
				m_tdata_q <= 16'h7fff;
			end else if (sat_lo) begin
				m_tdata_q <= 16'h8000;
			end else begin
				m_tdata_q <= q[fir_pkg::OUT_TDATA_W-1:0];
			end
			m_tuser_q <= sat_hi || sat_lo;
		end
	end

	// Delay line and coefficient store. While a sample is worked on, the
	// coefficient ring advances one digit a cycle and the delay ring one word
	// every tap; both are back home after the last tap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fir_pkg::MAX_TAPS; i++) begin
				delay_q[i] <= '0;
				coef_q[i]  <= '0;
			end
		end else begin
			if (s_fire && s_tuser == fir_pkg::OP_SAMPLE) begin
				// shift only the active taps, entries past the count stay zero
				delay_q[0] <= in_sample;
				for (int i = 1; i < fir_pkg::MAX_TAPS; i++) begin
					if (fir_pkg::CNT_W'(i) < tap_count_q) begin
						delay_q[i] <= delay_q[i-1];
					end
				end
			end else if (s_fire && s_tuser == fir_pkg::OP_LOAD) begin
				if ({1'b0, in_index} < tap_count_q) begin
					coef_q[in_index] <= in_coef;
				end
			end else if (state_q == ST_MAC) begin
				for (int i = 0; i < fir_pkg::MAX_TAPS - 1; i++) begin
					coef_q[i] <= {coef_q[i][fir_pkg::DATA_W-fir_pkg::DIGIT_W-1:0],
						coef_q[i+1][fir_pkg::DATA_W-1 -: fir_pkg::DIGIT_W]};
					if (last_digit) begin
						delay_q[i] <= delay_q[i+1];
					end
				end
				// close the rings: the last entry takes from the head
				coef_q[fir_pkg::MAX_TAPS-1] <=
					{coef_q[fir_pkg::MAX_TAPS-1][fir_pkg::DATA_W-fir_pkg::DIGIT_W-1:0],
					coef_q[0][fir_pkg::DATA_W-1 -: fir_pkg::DIGIT_W]};
				if (last_digit) begin
					delay_q[fir_pkg::MAX_TAPS-1] <= delay_q[0];
				end
			end
			if (cfg_fire && cfg_data != '0) begin
				for (int i = 0; i < fir_pkg::MAX_TAPS; i++) begin
					if (fir_pkg::CNT_W'(i) >= new_count) begin
						delay_q[i] <= '0;
						coef_q[i]  <= '0;
					end
				end
			end
		end
	end

	`FIR_ASSERT(a_tap_count_range, tap_count_q != '0 && tap_count_q <= fir_pkg::CNT_W'(fir_pkg::MAX_TAPS), "tap count out of range")
	`FIR_ASSERT(a_rings_home, state_q != ST_IDLE || (tap_q == '0 && digit_q == '0), "rings not home while idle")
	`FIR_ASSERT_NEXT(a_sample_starts, s_fire && s_tuser == fir_pkg::OP_SAMPLE, state_q == ST_MAC, "sample did not start the tap walk")
	`FIR_ASSERT_NEXT(a_load_silent, s_fire && s_tuser == fir_pkg::OP_LOAD && !m_tvalid_q, !m_tvalid_q, "coefficient load produced an output")

endmodule
